/* src/sbbp_pkg.sv */
// Shared types and constants of the static buffer block partitioner.
// No dependencies; imported by every module of the block.
package sbbp_pkg;

   localparam logic [2:0] FUNC_INIT    = 3'd0;
   localparam logic [2:0] FUNC_ACQUIRE = 3'd1;
   localparam logic [2:0] FUNC_ACCEPT  = 3'd2;
   localparam logic [2:0] FUNC_VACATE  = 3'd3;
   localparam logic [2:0] FUNC_DRAINED = 3'd4;

   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_BUSY      = 2'd1;
   localparam logic [1:0] STAT_MISMATCH  = 2'd2;
   localparam logic [1:0] STAT_SATURATED = 2'd3;

   localparam logic [0:0] REG_TOTAL_SIZE  = 1'd0;
   localparam logic [0:0] REG_BLOCK_COUNT = 1'd1;

   // Request to the shared divider and its answer.
   typedef struct packed {
      logic        start;
      logic [32:0] dividend;
      logic [32:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [32:0] quotient;
      logic [32:0] remainder;
   } div_rsp_type;

endpackage

/* src/static_buffer_block_partitioner.sv */
// Top level of the static buffer block partitioner: sequencer, slot table, registers.
// Depends on sbbp_pkg and sbbp_div.
//
//   channel  | ports                                   | handshake
//   request  | req_func, req_proc_id, req_count         | start & !busy
//   result   | rsp_owner/elements/offset/status/last    | rsp_valid, one cycle
//   config   | APB port, psel/penable/pwrite            | write in access phase
//
// Every valid request but vacate first maps proc_id to a slot through the shared divider.
// Init then runs one division per slot.
// Acquire, accept and drained then act on the mapped slot and reply; vacate walks
// the slots one per cycle and emits one word per non-empty slot, or a busy word if none.
// Reset is synchronous and clears the state, registers, slot count, flags and slot table.
// The receiver cannot stall: each result word shows for a single cycle.
module static_buffer_block_partitioner
   import sbbp_pkg::*;
#(
   parameter int MAX_SLOTS = 16
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_func,
   input  logic [15:0] req_proc_id,
   input  logic [31:0] req_count,
   output logic        rsp_valid,
   output logic [15:0] rsp_owner,
   output logic [31:0] rsp_elements,
   output logic [31:0] rsp_offset,
   output logic [1:0]  rsp_status,
   output logic        rsp_last,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int CW = $clog2(MAX_SLOTS + 1);

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_MAP    = 7'b0000010,
      ST_INIT   = 7'b0000100,
      ST_IDIV   = 7'b0001000,
      ST_EXEC   = 7'b0010000,
      ST_VACATE = 7'b0100000,
      ST_REPLY  = 7'b1000000
   } state_type;

   state_type   state_ff, state_in;
   logic [31:0] total_ff, total_in;
   logic [4:0]  bcnt_ff, bcnt_in;
   logic [CW-1:0] n_ff, n_in;
   logic [2:0]  func_ff, func_in;
   logic [15:0] pid_ff, pid_in;
   logic [31:0] cnt_ff, cnt_in;
   logic [IW-1:0] slot_ff, slot_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [31:0] base_ff, base_in;
   logic        found_ff, found_in;

   logic [31:0] sbase_ff [MAX_SLOTS];
   logic [31:0] ssize_ff [MAX_SLOTS];
   logic [31:0] sbeg_ff  [MAX_SLOTS];
   logic [31:0] send_ff  [MAX_SLOTS];
   logic [15:0] sown_ff  [MAX_SLOTS];
   logic [MAX_SLOTS-1:0] owned_ff, fresh_ff;

   logic        wr_en;
   logic [IW-1:0] wr_idx;
   logic [31:0] wr_base, wr_size, wr_beg, wr_end;
   logic [15:0] wr_own;
   logic        wr_owned, wr_fresh, clr_all;

   logic        v_in, l_in;
   logic [15:0] o_in;
   logic [31:0] e_in, f_in;
   logic [1:0]  s_in;
   logic        l_ff;
   logic [15:0] o_ff;
   logic [31:0] e_ff, f_ff;
   logic [1:0]  st_ff;

   div_req_type dreq;
   div_rsp_type drsp;

   sbbp_div u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   // Slot count clamped as init latches it.
   logic [CW-1:0] n_clamp;
   always_comb begin
      if (bcnt_ff == 5'd0) n_clamp = CW'(1);
      else if (32'(bcnt_ff) > 32'(MAX_SLOTS)) n_clamp = CW'(MAX_SLOTS);
      else n_clamp = CW'(bcnt_ff);
      if (32'(n_clamp) > total_ff) n_clamp = CW'(total_ff);
      if (n_clamp == '0) n_clamp = CW'(1);
   end

   logic [31:0] cb, ce, cbase, csize;
   logic [15:0] cown;
   logic        cowned, cfresh, pown;
   logic [32:0] lim, room;
   logic [31:0] held;
   logic [CW:0] mdiv;

   assign cb     = sbeg_ff[slot_ff];
   assign ce     = send_ff[slot_ff];
   assign cbase  = sbase_ff[slot_ff];
   assign csize  = ssize_ff[slot_ff];
   assign cown   = sown_ff[slot_ff];
   assign cowned = owned_ff[slot_ff];
   assign cfresh = fresh_ff[slot_ff];
   assign pown   = cowned && cown == pid_ff;
   assign mdiv   = {1'b0, n_ff} - {1'b0, idx_ff};

   always_comb begin
      state_in = state_ff;
      total_in = total_ff;
      bcnt_in  = bcnt_ff;
      n_in     = n_ff;
      func_in  = func_ff;
      pid_in   = pid_ff;
      cnt_in   = cnt_ff;
      slot_in  = slot_ff;
      idx_in   = idx_ff;
      base_in  = base_ff;
      found_in = found_ff;
      dreq     = '0;
      wr_en    = 1'b0;
      wr_idx   = slot_ff;
      wr_base  = cbase;
      wr_size  = csize;
      wr_beg   = cb;
      wr_end   = ce;
      wr_own   = cown;
      wr_owned = cowned;
      wr_fresh = cfresh;
      clr_all  = 1'b0;
      v_in = 1'b0; l_in = 1'b1; o_in = '0; e_in = '0; f_in = '0; s_in = STAT_OK;
      lim  = {1'b0, cbase} + {1'b0, csize};
      room = (lim > {1'b0, cb}) ? lim - {1'b0, cb} : '0;
      held = (ce > cb) ? ce - cb : '0;

      if (psel && penable && pwrite) begin
         if (paddr[2] == REG_TOTAL_SIZE) total_in = pwdata;
         else bcnt_in = pwdata[4:0];
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               func_in = req_func;
               pid_in  = req_proc_id;
               cnt_in  = req_count;
               idx_in  = '0;
               found_in = 1'b0;
               if (req_func == FUNC_VACATE) begin
                  state_in = ST_VACATE;
               end else if (req_func > FUNC_DRAINED) begin
                  v_in = 1'b1; s_in = STAT_MISMATCH;
               end else begin
                  if (req_func == FUNC_INIT) n_in = n_clamp;
                  dreq.start    = 1'b1;
                  dreq.dividend = {17'd0, req_proc_id};
                  dreq.divisor  = (req_func == FUNC_INIT) ?
                                  {{(33-CW){1'b0}}, n_clamp} :
                                  {{(33-CW){1'b0}}, n_ff};
                  state_in = ST_MAP;
               end
            end
         end
         ST_MAP: begin
            if (drsp.done) begin
               slot_in = IW'(drsp.remainder);
               if (func_ff == FUNC_INIT) begin
                  clr_all = 1'b1;
                  base_in = '0;
                  state_in = ST_INIT;
               end else begin
                  state_in = ST_EXEC;
               end
            end
         end
         ST_INIT: begin
            if (idx_ff == n_ff) begin
               state_in = ST_REPLY;
            end else begin
               dreq.start    = 1'b1;
               dreq.dividend = {1'b0, total_ff - base_ff} + 33'(mdiv >> 1);
               dreq.divisor  = 33'(mdiv);
               state_in = ST_IDIV;
            end
         end
         ST_IDIV: begin
            if (drsp.done) begin
               wr_en    = 1'b1;
               wr_idx   = IW'(idx_ff);
               wr_base  = base_ff;
               wr_size  = drsp.quotient[31:0];
               wr_beg   = base_ff;
               wr_end   = base_ff;
               wr_own   = '0;
               wr_owned = 1'b0;
               wr_fresh = 1'b0;
               base_in  = base_ff + drsp.quotient[31:0];
               idx_in   = idx_ff + CW'(1);
               state_in = ST_INIT;
            end
         end
         ST_EXEC: begin
            state_in = ST_REPLY;
            case (func_ff)
               FUNC_ACQUIRE: begin
                  if (cb < ce) begin
                     v_in = 1'b1; o_in = cown; f_in = cb; s_in = STAT_BUSY;
                     state_in = ST_IDLE;
                  end else begin
                     wr_en = 1'b1;
                     wr_own = pid_ff; wr_owned = 1'b1; wr_fresh = 1'b1;
                     wr_beg = cbase;
                     wr_end = cbase + ((csize < cnt_ff) ? csize : cnt_ff);
                  end
               end
               FUNC_ACCEPT: begin
                  if (!cfresh || !pown) begin
                     found_in = 1'b1;
                  end else begin
                     wr_en = 1'b1; wr_fresh = 1'b0;
                     if ({1'b0, cnt_ff} > room) begin
                        wr_end = cb + room[31:0];
                        found_in = 1'b0;
                        idx_in = CW'(1);
                     end else begin
                        wr_end = cb + cnt_ff;
                     end
                  end
               end
               FUNC_DRAINED: begin
                  if (!pown || cb >= ce) begin
                     found_in = 1'b1;
                  end else begin
                     wr_en = 1'b1;
                     if (cnt_ff > held) begin
                        wr_beg = ce; idx_in = CW'(1);
                     end else begin
                        wr_beg = cb + cnt_ff;
                     end
                  end
               end
               default: ;
            endcase
         end
         ST_VACATE: begin
            // One slot per cycle; a word is held back until the next one is known.
            if (idx_ff == n_ff) begin
               state_in = ST_IDLE;
               if (found_ff) begin
                  v_in = 1'b1; o_in = o_ff; e_in = e_ff; f_in = f_ff;
               end else begin
                  v_in = 1'b1; s_in = STAT_BUSY;
               end
            end else begin
               if (sbeg_ff[IW'(idx_ff)] < send_ff[IW'(idx_ff)]) begin
                  found_in = 1'b1;
                  if (found_ff) begin
                     v_in = 1'b1; l_in = 1'b0; o_in = o_ff; e_in = e_ff; f_in = f_ff;
                  end
               end
               idx_in = idx_ff + CW'(1);
            end
         end
         ST_REPLY: begin
            v_in = 1'b1;
            o_in = pid_ff;
            e_in = pown ? held : '0;
            f_in = cb;
            if (func_ff == FUNC_INIT || func_ff == FUNC_ACQUIRE) s_in = STAT_OK;
            else if (found_ff) s_in = STAT_MISMATCH;
            else if (idx_ff == CW'(1)) s_in = STAT_SATURATED;
            else s_in = STAT_OK;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // The held vacate word keeps its value across empty slots until it is sent.
   logic [15:0] vo;
   logic [31:0] ve, vf;
   assign vo = sown_ff[IW'(idx_ff)];
   assign ve = send_ff[IW'(idx_ff)] - sbeg_ff[IW'(idx_ff)];
   assign vf = sbeg_ff[IW'(idx_ff)];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         total_ff <= 32'd1024;
         bcnt_ff  <= 5'd1;
         n_ff     <= CW'(1);
         owned_ff <= '0;
         fresh_ff <= '0;
         found_ff <= 1'b0;
         for (int i = 0; i < MAX_SLOTS; i++) begin
            sbase_ff[i] <= '0; ssize_ff[i] <= '0; sbeg_ff[i] <= '0;
            send_ff[i]  <= '0; sown_ff[i]  <= '0;
         end
      end else begin
         state_ff <= state_in;
         total_ff <= total_in;
         bcnt_ff  <= bcnt_in;
         n_ff     <= n_in;
         found_ff <= found_in;
         if (clr_all) begin
            owned_ff <= '0;
            fresh_ff <= '0;
            for (int i = 0; i < MAX_SLOTS; i++) begin
               sbase_ff[i] <= '0; ssize_ff[i] <= '0; sbeg_ff[i] <= '0;
               send_ff[i]  <= '0; sown_ff[i]  <= '0;
            end
         end else if (wr_en) begin
            sbase_ff[wr_idx] <= wr_base;
            ssize_ff[wr_idx] <= wr_size;
            sbeg_ff[wr_idx]  <= wr_beg;
            send_ff[wr_idx]  <= wr_end;
            sown_ff[wr_idx]  <= wr_own;
            owned_ff[wr_idx] <= wr_owned;
            fresh_ff[wr_idx] <= wr_fresh;
         end
      end
      func_ff <= func_in;
      pid_ff  <= pid_in;
      cnt_ff  <= cnt_in;
      slot_ff <= slot_in;
      idx_ff  <= idx_in;
      base_ff <= base_in;
      l_ff  <= l_in;
      st_ff <= s_in;
      if (state_ff == ST_VACATE && idx_ff != n_ff &&
          sbeg_ff[IW'(idx_ff)] < send_ff[IW'(idx_ff)]) begin
         o_ff <= vo; e_ff <= ve; f_ff <= vf;
      end
   end

   // In vacate the strobed word comes from the previously captured slot.
   logic        vac_hold_ff;
   logic [15:0] ro_ff;
   logic [31:0] re_ff, rf_ff;
   always_ff @(posedge clock) begin
      if (reset) vac_hold_ff <= 1'b0;
      else vac_hold_ff <= v_in;
      ro_ff <= o_in; re_ff <= e_in; rf_ff <= f_in;
   end

   assign busy         = (state_ff != ST_IDLE);
   assign rsp_valid    = vac_hold_ff;
   assign rsp_owner    = ro_ff;
   assign rsp_elements = re_ff;
   assign rsp_offset   = rf_ff;
   assign rsp_status   = st_ff;
   assign rsp_last     = l_ff;
   assign pready       = 1'b1;
   assign prdata       = (paddr[2] == REG_TOTAL_SIZE) ? total_ff : {27'd0, bcnt_ff};

   a_busy_no_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && !$past(start)) |-> !rsp_valid || $past(busy))
      else $error("result strobe without a request");
   a_n_range: assert property (@(posedge clock) disable iff (reset)
      n_ff != '0 && 32'(n_ff) <= 32'(MAX_SLOTS))
      else $error("latched slot count out of range");
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      drsp.done |-> (state_ff == ST_MAP || state_ff == ST_IDIV))
      else $error("divider finished outside a wait state");

   logic unused_ok;
   assign unused_ok = ^{paddr[1:0], drsp.quotient[32]};

endmodule

/* src/sbbp_div.sv */
// Shared restoring divider, one quotient bit per cycle.
// Depends on sbbp_pkg.
module sbbp_div
   import sbbp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic [32:0] quo_ff, quo_in;
   logic [32:0] rem_ff, rem_in;
   logic [32:0] dsr_ff, dsr_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        run_ff, run_in;
   logic        done_ff, done_in;
   logic [33:0] trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[32]} - {1'b0, dsr_ff};
      if (req.start) begin
         quo_in = req.dividend;
         rem_in = '0;
         dsr_in = req.divisor;
         cnt_in = 6'd33;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (!trial[33]) begin
            rem_in = trial[32:0];
            quo_in = {quo_ff[31:0], 1'b1};
         end else begin
            rem_in = {rem_ff[31:0], quo_ff[32]};
            quo_in = {quo_ff[31:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign rsp.done      = done_ff;
   assign rsp.quotient  = quo_ff;
   assign rsp.remainder = rem_ff;

endmodule
